[sv/pgcu_pkg.sv]
// Shared types, state codes and the per-opcode parameter count table.
package pgcu_pkg;

  localparam int OpW    = 8;
  localparam int WordW  = 32;
  localparam int DopW   = 7;
  localparam int CountW = 6;
  localparam int MaxOut = 4;
  localparam int NumW   = $clog2(MaxOut);

  typedef logic [OpW-1:0]    opcode_t;
  typedef logic [WordW-1:0]  word_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [NumW-1:0]   num_t;

  localparam logic CMD_PACKED = 1'b0;
  localparam logic CMD_DIRECT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  // Number of parameter words each geometry command takes.
  function automatic count_t op_arg_count(input opcode_t op);
    count_t cnt;
    cnt = '0;
    unique case (op) inside
      8'h10, 8'h12, 8'h13, 8'h14,
      8'h20, 8'h21, 8'h22, 8'h24, 8'h25, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2A, 8'h2B,
      8'h30, 8'h31, 8'h32, 8'h33,
      8'h40, 8'h50, 8'h60, 8'h72:  cnt = 6'd1;
      8'h23, 8'h71:                cnt = 6'd2;
      8'h1B, 8'h1C, 8'h70:         cnt = 6'd3;
      8'h1A:                       cnt = 6'd9;
      8'h17, 8'h19:                cnt = 6'd12;
      8'h16, 8'h18:                cnt = 6'd16;
      8'h34:                       cnt = 6'd32;
      default:                     cnt = 6'd0;
    endcase
    return cnt;
  endfunction

endpackage

[sv/pgcu_out_stage.sv]
// Output register for queue entries with valid/stall handshake.
module pgcu_out_stage
  import pgcu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  opcode_t ld_opcode,
  input  word_t   ld_param,
  input  logic    ld_last,
  output logic    free,
  output logic    out_valid,
  input  logic    out_stall,
  output opcode_t opcode,
  output word_t   parameter_res,
  output logic    last
);

  // The register can take a new entry when empty or when its entry leaves now.
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      opcode        <= ld_opcode;
      parameter_res <= ld_param;
      last          <= ld_last;
    end
  end

endmodule

[sv/packed_geometry_command_unpacker_top.sv]
// Top level of the packed geometry command unpacker.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | in_valid / in_stall  | command, direct_opcode, data
//   output   | out_valid / out_stall| opcode, parameter_res, last
//
// A request is registered while idle and executed in S_EXEC, where a direct
// or parameter write emits its first entry and a packed load takes the word.
// Each further entry comes from S_SCAN as the pending word shifts a byte, and a
// load always passes through S_SCAN at least once.
// Synchronous reset clears the pending word, the parameter counter and control.
// Output stalls hold the sequencer; the input is stalled while a request runs.
module packed_geometry_command_unpacker_top
  import pgcu_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            command,
  input  logic [DopW-1:0] direct_opcode,
  input  word_t           data,
  output logic            out_valid,
  input  logic            out_stall,
  output opcode_t         opcode,
  output word_t           parameter_res,
  output logic            last
);

  state_t state, state_next;

  logic            cmd_q;
  logic [DopW-1:0] dop_q;
  word_t           data_q;

  word_t  pending, pending_next;
  count_t params_received, params_received_next;
  num_t   emitted, emitted_next;

  logic    free;
  logic    load;
  opcode_t ld_opcode;
  word_t   ld_param;
  logic    ld_last;

  opcode_t low_op;
  opcode_t next_op;
  word_t   pending_shift;
  count_t  low_cnt;
  count_t  params_inc;
  logic    retire;
  logic    param_last;
  logic    zero_last;

  assign in_stall = (state != S_IDLE);

  assign low_op        = pending[OpW-1:0];
  assign next_op       = pending[2*OpW-1:OpW];
  assign pending_shift = pending >> OpW;
  assign low_cnt       = op_arg_count(low_op);
  assign params_inc    = params_received + count_t'(1);
  assign retire        = (params_inc == low_cnt);

  // A parameter entry ends the request unless the opcode retires, the shifted
  // pending word is nonzero and its next opcode takes no parameters.
  assign param_last = !retire || (pending_shift == '0) ||
                      (op_arg_count(pending_shift[OpW-1:0]) != '0);

  // A parameterless entry ends the request if no parameterless one follows or it is entry MaxOut of the request.
  assign zero_last = (pending_shift == '0) || (op_arg_count(next_op) != '0) ||
                     (emitted == num_t'(MaxOut - 1));

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q  <= command;
      dop_q  <= direct_opcode;
      data_q <= data;
    end
  end

  always_comb begin
    state_next           = state;
    pending_next         = pending;
    params_received_next = params_received;
    emitted_next         = emitted;
    load                 = 1'b0;
    ld_opcode            = low_op;
    ld_param             = data_q;
    ld_last              = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_q == CMD_DIRECT) begin
          if (free) begin
            load       = 1'b1;
            ld_opcode  = {1'b0, dop_q};
            state_next = S_IDLE;
          end
        end else if (pending == '0) begin
          pending_next = data_q;
          emitted_next = '0;
          state_next   = S_SCAN;
        end else if (free) begin
          load         = 1'b1;
          ld_last      = param_last;
          emitted_next = num_t'(1);
          if (retire) begin
            pending_next         = pending_shift;
            params_received_next = '0;
          end else begin
            params_received_next = params_inc;
          end
          state_next = param_last ? S_IDLE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (pending == '0 || low_cnt != '0) begin
          state_next = S_IDLE;
        end else if (free) begin
          load         = 1'b1;
          ld_param     = '0;
          ld_last      = zero_last;
          pending_next = pending_shift;
          emitted_next = emitted + num_t'(1);
          if (zero_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pending         <= '0;
      params_received <= '0;
      emitted         <= '0;
    end else begin
      state           <= state_next;
      pending         <= pending_next;
      params_received <= params_received_next;
      emitted         <= emitted_next;
    end
  end

  pgcu_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .ld_opcode    (ld_opcode),
    .ld_param     (ld_param),
    .ld_last      (ld_last),
    .free         (free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .opcode       (opcode),
    .parameter_res(parameter_res),
    .last         (last)
  );

endmodule

[tb/tb_packed_geometry_command_unpacker_top.sv]
// Self-checking testbench for the packed geometry command unpacker top level.
`timescale 1ns / 100ps

module tb_packed_geometry_command_unpacker_top
  import pgcu_pkg::*;
();

  localparam int CycleLimit = 100000;
  localparam int TailCycles = 12;
  localparam int HoldCycles = 80;

  // Parameter counts of opcodes 0x10 to 0x1F, listed from the lowest opcode.
  localparam logic [0:15][7:0] Row1xArgs = {
    8'd1, 8'd0, 8'd1, 8'd1, 8'd1, 8'd0, 8'd16, 8'd12,
    8'd16, 8'd12, 8'd9, 8'd3, 8'd3, 8'd0, 8'd0, 8'd0
  };

  typedef struct packed {
    opcode_t op;
    word_t   param;
    logic    last;
  } entry_t;

  logic            clk;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            command = CMD_PACKED;
  logic [DopW-1:0] direct_opcode = '0;
  word_t           data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  opcode_t         opcode;
  word_t           parameter_res;
  logic            last;

  entry_t      entries_due[$];
  word_t       pend_word = '0;
  count_t      args_taken = '0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          idle_on = 1'b1;

  packed_geometry_command_unpacker_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .direct_opcode (direct_opcode),
    .data          (data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .opcode        (opcode),
    .parameter_res (parameter_res),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic count_t arg_count(input opcode_t op);
    count_t n;
    n = '0;
    case (op[7:4])
      4'h1: n = count_t'(Row1xArgs[op[3:0]]);
      4'h2: n = (op[3:0] == 4'h3) ? count_t'(2) : (op[3:0] < 4'hC) ? count_t'(1) : '0;
      4'h3: n = (op[3:0] < 4'h4) ? count_t'(1) : (op[3:0] == 4'h4) ? count_t'(32) : '0;
      4'h4, 4'h5, 4'h6: n = (op[3:0] == 4'h0) ? count_t'(1) : '0;
      4'h7: n = (op[3:0] < 4'h3) ? count_t'(3 - op[3:0]) : '0;
      default: n = '0;
    endcase
    return n;
  endfunction

  // Updates the shadow unpacker state and queues the entries one request releases.
  task automatic unpack_request(input logic cmd, input logic [DopW-1:0] dop,
                                input word_t d);
    entry_t  released[$];
    opcode_t head;
    if (cmd == CMD_DIRECT) begin
      released.push_back('{op: {1'b0, dop}, param: d, last: 1'b0});
    end else begin
      if (pend_word == '0) begin
        pend_word = d;
      end else begin
        head = pend_word[7:0];
        released.push_back('{op: head, param: d, last: 1'b0});
        args_taken = args_taken + 1'b1;
        if (args_taken == arg_count(head)) begin
          pend_word = pend_word >> 8;
          args_taken = '0;
        end
      end
      while (pend_word != '0 && released.size() < MaxOut &&
             arg_count(pend_word[7:0]) == '0) begin
        released.push_back('{op: pend_word[7:0], param: '0, last: 1'b0});
        pend_word = pend_word >> 8;
      end
    end
    if (released.size() > 0) released[released.size()-1].last = 1'b1;
    foreach (released[i]) entries_due.push_back(released[i]);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("ERROR at %0t ns: %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic send_request(input logic cmd, input logic [DopW-1:0] dop,
                              input word_t d);
    while (idle_on && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    direct_opcode <= dop;
    data          <= d;
    do @(posedge clk); while (in_stall);
    unpack_request(cmd, dop, d);
  endtask

  // The sender stops until every queued entry has come out, then lets the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (entries_due.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  function automatic opcode_t pick_opcode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return opcode_t'($urandom_range(15));
    if (r < 40) return opcode_t'($urandom_range(255, 128));
    if (r < 75) return opcode_t'(8'h20 + $urandom_range(11));
    if (r < 85) begin
      case ($urandom_range(3))
        0: return 8'h70;
        1: return 8'h71;
        2: return 8'h1B;
        default: return 8'h1C;
      endcase
    end
    if (r < 90) return opcode_t'(8'h10 * $urandom_range(6, 3));
    if (r < 97) return ($urandom_range(1) == 0) ? 8'h1A : 8'h17;
    case ($urandom_range(2))
      0: return 8'h16;
      1: return 8'h18;
      default: return 8'h34;
    endcase
  endfunction

  function automatic word_t build_load_word();
    return {pick_opcode(), pick_opcode(), pick_opcode(), pick_opcode()};
  endfunction

  task automatic test_direct_port();
    send_request(CMD_DIRECT, 7'h00, 32'h0000_0000);
    send_request(CMD_DIRECT, 7'h7F, 32'hFFFF_FFFF);
    send_request(CMD_DIRECT, 7'h55, 32'hA5A5_A5A5);
    send_request(CMD_DIRECT, 7'h2A, 32'h5A5A_5A5A);
    wait_drained();
  endtask

  task automatic test_packed_directed();
    // A zero word with nothing pending loads nothing.
    send_request(CMD_PACKED, 7'h00, 32'h0000_0000);
    send_request(CMD_PACKED, 7'h00, 32'h0504_0302);
    // Zero opcode bytes ahead of a nonzero byte are still emitted.
    send_request(CMD_PACKED, 7'h00, 32'h0100_0000);
    send_request(CMD_PACKED, 7'h00, 32'hFF80_1172);
    send_request(CMD_PACKED, 7'h00, 32'hFFFF_FFFF);
    send_request(CMD_PACKED, 7'h00, 32'h0071_0010);
    // A direct write in the middle of a packed sequence leaves it untouched.
    send_request(CMD_DIRECT, 7'h7F, 32'h1234_5678);
    send_request(CMD_PACKED, 7'h7F, 32'h0000_0000);
    send_request(CMD_PACKED, 7'h00, 32'h0000_0001);
    send_request(CMD_PACKED, 7'h00, 32'h0000_0002);
    send_request(CMD_PACKED, 7'h00, 32'h0000_1B23);
    repeat (5) send_request(CMD_PACKED, 7'($urandom), $urandom);
    send_request(CMD_PACKED, 7'h00, 32'h0000_0000);
    wait_drained();
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_left = HoldCycles;
    @(posedge clk);
    // Four-entry loads hold the sequencer behind the held output, so the input stays stalled.
    repeat (12) begin
      send_request(CMD_PACKED, 7'($urandom),
                   {4{opcode_t'($urandom_range(15, 1))}});
    end
    wait_drained();
  endtask

  task automatic test_random_stream();
    int unsigned roll;
    idle_on = 1'b0;
    for (int i = 0; i < 100; i++) begin
      if (i == 45) idle_on = 1'b1;
      roll = $urandom_range(99);
      if (roll < 12) send_request(CMD_DIRECT, 7'($urandom), $urandom);
      else if (pend_word != '0) send_request(CMD_PACKED, 7'($urandom), $urandom);
      else if (roll < 24) send_request(CMD_PACKED, 7'($urandom), $urandom);
      else send_request(CMD_PACKED, 7'($urandom), build_load_word());
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 13);
    end
  end

  always @(posedge clk) begin : check_output
    entry_t want;
    if (!rst && out_valid && !out_stall) begin
      if (entries_due.size() == 0) begin
        flag_mismatch("entry with none queued, opcode", 32'(opcode), 32'h0);
      end else begin
        want = entries_due.pop_front();
        if (opcode !== want.op) flag_mismatch("opcode", 32'(opcode), 32'(want.op));
        if (parameter_res !== want.param)
          flag_mismatch("parameter_res", parameter_res, want.param);
        if (last !== want.last) flag_mismatch("last", 32'(last), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d entries outstanding",
               cycle_count, entries_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_direct_port();
    test_packed_directed();
    test_backpressure();
    test_random_stream();
    if (entries_due.size() != 0) begin
      $display("ERROR: %0d expected entries never arrived", entries_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
